>>> design/pcxrle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX RLE line encoder package
// Shared constants, the flush entry passed from front to back, and helpers.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

    localparam logic [15:0] LINE_WIDTH_RESET    = 16'd640;
    localparam logic [5:0]  MAX_RUN             = 6'h3f;
    localparam logic [1:0]  COUNT_MARK          = 2'b11;
    localparam int          QUEUE_DEPTH_DEFAULT = 4;

    // Output byte positions within one entry, in emission order.
    typedef enum logic [1:0] {
        SLOT_A_COUNT = 2'd0,
        SLOT_A_VALUE = 2'd1,
        SLOT_B_COUNT = 2'd2,
        SLOT_B_VALUE = 2'd3
    } slot_t;

    // Run A is the run closed by the arriving pixel, run B the run flushed
    // at the end of the line. Each set bit of slot_mask is one byte to send.
    typedef struct packed {
        logic [7:0] a_value;
        logic [5:0] a_length;
        logic [7:0] b_value;
        logic [5:0] b_length;
        logic [3:0] slot_mask;
    } flush_entry_t;

    // A count byte precedes the value when the run is longer than one pixel
    // or the value itself would read as a count byte.
    function automatic logic count_needed(input logic [7:0] value,
                                          input logic [5:0] length);
        count_needed = (length > 6'd1) || (value[7:6] == COUNT_MARK);
    endfunction

endpackage

>>> design/pcxrle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX RLE front end
// Accepts pixels, tracks the open run and the column, and queues flush work.
// ----------------------------------------------------------------------------
module pcxrle_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                pixel,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [15:0]               line_width,
    output logic                      push_valid,
    input  logic                      push_ready,
    output pcxrle_pkg::flush_entry_t  push_data
);

    logic [15:0] line_width_reg, line_width_next;
    logic [7:0]  run_value_reg, run_value_next;
    logic [5:0]  run_length_reg, run_length_next;
    logic [15:0] column_reg, column_next;

    logic        accept;
    logic        run_open;
    logic        close_a;
    logic [5:0]  new_length;
    logic [16:0] next_column;
    logic        end_line;

    assign cfg_ready = 1'b1;
    assign in_ready  = push_ready;
    assign accept    = in_valid && in_ready;

    assign run_open    = (run_length_reg != 6'd0);
    assign close_a     = run_open &&
                         ((pixel != run_value_reg) || (run_length_reg >= pcxrle_pkg::MAX_RUN));
    assign new_length  = (!run_open || close_a) ? 6'd1 : run_length_reg + 6'd1;
    assign next_column = {1'b0, column_reg} + 17'd1;
    // A width of zero compares as always reached, so every pixel ends a line.
    assign end_line    = (next_column >= {1'b0, line_width_reg});

    always_comb
    begin
        push_data.a_value   = run_value_reg;
        push_data.a_length  = run_length_reg;
        push_data.b_value   = pixel;
        push_data.b_length  = new_length;
        push_data.slot_mask[pcxrle_pkg::SLOT_A_COUNT] =
            close_a && pcxrle_pkg::count_needed(run_value_reg, run_length_reg);
        push_data.slot_mask[pcxrle_pkg::SLOT_A_VALUE] = close_a;
        push_data.slot_mask[pcxrle_pkg::SLOT_B_COUNT] =
            end_line && pcxrle_pkg::count_needed(pixel, new_length);
        push_data.slot_mask[pcxrle_pkg::SLOT_B_VALUE] = end_line;
        push_valid = accept && (close_a || end_line);
    end

    always_comb
    begin
        line_width_next = line_width_reg;
        run_value_next  = run_value_reg;
        run_length_next = run_length_reg;
        column_next     = column_reg;
        if (cfg_valid && cfg_ready)
        begin
            line_width_next = line_width;
        end
        if (accept)
        begin
            if (end_line)
            begin
                run_value_next  = 8'd0;
                run_length_next = 6'd0;
                column_next     = 16'd0;
            end
            else
            begin
                run_value_next  = pixel;
                run_length_next = new_length;
                column_next     = next_column[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= pcxrle_pkg::LINE_WIDTH_RESET;
            run_value_reg  <= 8'd0;
            run_length_reg <= 6'd0;
            column_reg     <= 16'd0;
        end
        else
        begin
            line_width_reg <= line_width_next;
            run_value_reg  <= run_value_next;
            run_length_reg <= run_length_next;
            column_reg     <= column_next;
        end
    end

endmodule

>>> design/pcxrle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX RLE flush queue
// Small first-in first-out queue of flush entries between front and back.
// ----------------------------------------------------------------------------
module pcxrle_queue
#(
    parameter int DEPTH = pcxrle_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push_valid,
    output logic                      push_ready,
    input  pcxrle_pkg::flush_entry_t  push_data,
    output logic                      pop_valid,
    input  logic                      pop_ready,
    output pcxrle_pkg::flush_entry_t  pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pcxrle_pkg::flush_entry_t entries_reg [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/pcxrle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX RLE back end
// Expands each flush entry into count and value bytes, one byte per cycle while out_ready holds.
// ----------------------------------------------------------------------------
module pcxrle_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  pcxrle_pkg::flush_entry_t  pop_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                out_byte,
    output logic                      last_of_item,
    output logic                      end_of_line
);

    pcxrle_pkg::flush_entry_t cur_reg, cur_next;
    logic                     cur_valid_reg, cur_valid_next;
    logic                     out_valid_reg, out_valid_next;
    logic [7:0]               out_byte_reg, out_byte_next;
    logic                     last_reg, last_next;
    logic                     eol_reg, eol_next;

    pcxrle_pkg::slot_t sel;
    logic [3:0]        rest_mask;
    logic [7:0]        sel_byte;
    logic              emit;
    logic              done;

    // Lowest pending slot goes out first.
    always_comb
    begin
        if (cur_reg.slot_mask[pcxrle_pkg::SLOT_A_COUNT])
        begin
            sel = pcxrle_pkg::SLOT_A_COUNT;
        end
        else if (cur_reg.slot_mask[pcxrle_pkg::SLOT_A_VALUE])
        begin
            sel = pcxrle_pkg::SLOT_A_VALUE;
        end
        else if (cur_reg.slot_mask[pcxrle_pkg::SLOT_B_COUNT])
        begin
            sel = pcxrle_pkg::SLOT_B_COUNT;
        end
        else
        begin
            sel = pcxrle_pkg::SLOT_B_VALUE;
        end
    end

    always_comb
    begin
        case (sel)
            pcxrle_pkg::SLOT_A_COUNT: sel_byte = {pcxrle_pkg::COUNT_MARK, cur_reg.a_length};
            pcxrle_pkg::SLOT_A_VALUE: sel_byte = cur_reg.a_value;
            pcxrle_pkg::SLOT_B_COUNT: sel_byte = {pcxrle_pkg::COUNT_MARK, cur_reg.b_length};
            pcxrle_pkg::SLOT_B_VALUE: sel_byte = cur_reg.b_value;
            default:                  sel_byte = cur_reg.b_value;
        endcase
    end

    assign rest_mask = cur_reg.slot_mask & ~(4'b0001 << sel);
    assign emit      = cur_valid_reg && (!out_valid_reg || out_ready);
    assign done      = emit && (rest_mask == 4'b0000);
    assign pop_ready = !cur_valid_reg || done;

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        eol_next       = eol_reg;

        if (pop_valid && pop_ready)
        begin
            cur_next       = pop_data;
            cur_valid_next = 1'b1;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            cur_next.slot_mask = rest_mask;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = sel_byte;
            last_next      = (rest_mask == 4'b0000);
            eol_next       = (sel == pcxrle_pkg::SLOT_B_VALUE);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        eol_reg      <= eol_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_item = last_reg;
    assign end_of_line  = eol_reg;

endmodule

>>> design/pcx_rle_line_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX RLE line encoder
// Run-length encodes 8-bit palette pixels into PCX bytes per scanline.
// ----------------------------------------------------------------------------
// A pixel is taken in every cycle while the flush queue has room; pixels that
// only extend or open a run produce nothing. Bytes leave at one per cycle
// from the output register while out_ready is high; a pixel that closes runs
// causes one or two bytes for a closed run, and up to four when a run closes
// and the line ends on the same pixel. The back end's single output byte per
// cycle, while out_ready is high, sets the sustained rate. The first byte of
// a flush passes from the queue entry through the back end's current-entry
// register to the output register. line_width may be written at any time the
// encoder is idle; the open run and the column are kept across the write.
module pcx_rle_line_encoder_unit
#(
    parameter int QUEUE_DEPTH = pcxrle_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] line_width,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_item,
    output logic        end_of_line
);

    logic                     push_valid;
    logic                     push_ready;
    pcxrle_pkg::flush_entry_t push_data;
    logic                     pop_valid;
    logic                     pop_ready;
    pcxrle_pkg::flush_entry_t pop_data;

    pcxrle_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .line_width (line_width),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    pcxrle_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pcxrle_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .end_of_line  (end_of_line)
    );

endmodule

>>> design/pcxrle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX RLE line encoder checker
// Port-level checks on the encoder's output stream and configuration port, bound to the top level.
// ----------------------------------------------------------------------------
module pcxrle_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_item,
    input logic       end_of_line
);

    // An offered item is held until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("output item dropped or changed while stalled");

    // The end of a line always closes the bytes of its pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_line |-> last_of_item)
        else $error("end of line on a byte that is not the last of its pixel");

    // Bytes of one pixel are offered back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_item |=> out_valid)
        else $error("gap inside the bytes of one pixel");

    // Configuration writes are never refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind pcx_rle_line_encoder_unit pcxrle_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ready    (cfg_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .end_of_line  (end_of_line)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX RLE line encoder testbench
// Drives palette pixels under directed and random line widths and compares every encoded
// byte against a run-length predictor kept in step with each accepted item.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_PERIOD    = 10;
    localparam int LATENCY       = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PIXELS = 260;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       eol;
    } enc_byte_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  pixel;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] line_width;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        last_of_item;
    logic        end_of_line;

    // Predictor state: the open run, the column and the width in force.
    logic [7:0]  enc_run_value;
    logic [5:0]  enc_run_length;
    logic [15:0] enc_column;
    logic [15:0] enc_width;

    enc_byte_t   step_bytes [4];
    int          step_count;
    enc_byte_t   expected_bytes [$];
    enc_byte_t   next_expected;

    int          error_count;
    int          cycle_count;
    int          burst_left;
    logic        hold_request;

    pcx_rle_line_encoder_unit uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .line_width   (line_width),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .end_of_line  (end_of_line)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[pcx_rle_line_encoder_unit] ERROR");
            $finish;
        end
    end

    // A count byte goes out ahead of the value when the run is longer than
    // one pixel or the value has both top bits set.
    function automatic void emit_run();
        if (enc_run_length > 6'd1 || enc_run_value[7:6] == pcxrle_pkg::COUNT_MARK)
        begin
            step_bytes[step_count] = {pcxrle_pkg::COUNT_MARK, enc_run_length, 2'b00};
            step_count++;
        end
        step_bytes[step_count] = {enc_run_value, 2'b00};
        step_count++;
    endfunction

    function automatic void encode_pixel(input logic [7:0] px);
        logic [16:0] next_col;
        int          i;
        step_count = 0;
        if (enc_run_length == 6'd0)
        begin
            enc_run_value  = px;
            enc_run_length = 6'd1;
        end
        else if (px != enc_run_value || enc_run_length >= pcxrle_pkg::MAX_RUN)
        begin
            emit_run();
            enc_run_value  = px;
            enc_run_length = 6'd1;
        end
        else
        begin
            enc_run_length = enc_run_length + 6'd1;
        end
        next_col = {1'b0, enc_column} + 17'd1;
        if (next_col >= {1'b0, enc_width})
        begin
            emit_run();
            step_bytes[step_count - 1].eol = 1'b1;
            enc_run_value  = 8'd0;
            enc_run_length = 6'd0;
            enc_column     = 16'd0;
        end
        else
        begin
            enc_column = next_col[15:0];
        end
        if (step_count > 0)
            step_bytes[step_count - 1].last = 1'b1;
        for (i = 0; i < step_count; i++)
            expected_bytes.push_back(step_bytes[i]);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected out_byte %h with nothing pending", out_byte);
                error_count++;
            end
            else
            begin
                next_expected = expected_bytes.pop_front();
                if (out_byte !== next_expected.value)
                begin
                    $error("out_byte: expected %h, got %h", next_expected.value, out_byte);
                    error_count++;
                end
                if (last_of_item !== next_expected.last)
                begin
                    $error("last_of_item: expected %b, got %b",
                           next_expected.last, last_of_item);
                    error_count++;
                end
                if (end_of_line !== next_expected.eol)
                begin
                    $error("end_of_line: expected %b, got %b",
                           next_expected.eol, end_of_line);
                    error_count++;
                end
            end
        end
    end

    // Receiver: switches at random among stall patterns and
    // honors a long hold-off when a test asks for one.
    initial
    begin : receiver
        int mode;
        int mode_left;
        int tick;
        out_ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            tick++;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 1) == 0);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= tick[2];
            endcase
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_pixel(input logic [7:0] px);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        pixel    <= px;
        do
            @(posedge clk);
        while (!in_ready);
        encode_pixel(px);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_width(input logic [15:0] w);
        wait_idle();
        cfg_valid  <= 1'b1;
        line_width <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        enc_width = w;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Default width of 640 is in force until the first write.
    task automatic test_reset_width();
        send_pixel(8'h12);
        send_pixel(8'h12);
        send_pixel(8'h34);
    endtask

    // With width zero every pixel is a line of its own; the run left open by
    // the previous test is closed by the first pixel.
    task automatic test_zero_width();
        write_width(16'd0);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'hC0);
        send_pixel(8'hBF);
    endtask

    // A closed run and the line end on the same pixel give four bytes.
    task automatic test_line_end();
        write_width(16'd4);
        send_pixel(8'h55);
        send_pixel(8'h55);
        send_pixel(8'h55);
        send_pixel(8'hC3);
        write_width(16'd3);
        send_pixel(8'h80);
        send_pixel(8'h80);
        send_pixel(8'h80);
    endtask

    // Lowering the width below the current column ends the line at once.
    task automatic test_width_lowered();
        int i;
        write_width(16'hFFFF);
        for (i = 0; i < 5; i++)
            send_pixel(8'h7F);
        send_pixel(8'h01);
        write_width(16'd2);
        send_pixel(8'h01);
    endtask

    // The receiver holds off while pixels keep coming, so the input stalls.
    task automatic test_output_stall();
        int i;
        write_width(16'd1);
        hold_request = 1'b1;
        for (i = 0; i < 40; i++)
            send_pixel(8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_lines();
        int         sent;
        int         budget;
        int         run_len;
        logic [7:0] value;
        logic [7:0] prev_value;
        logic [15:0] w;
        sent       = 0;
        prev_value = 8'h00;
        while (sent < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 9))
                0:       w = 16'd0;
                1:       w = 16'd1;
                2:       w = 16'($urandom_range(2, 8));
                8:       w = 16'hFFFF;
                9:       w = 16'($urandom_range(1, 65535));
                default: w = 16'($urandom_range(9, 150));
            endcase
            write_width(w);
            budget = $urandom_range(15, 60);
            while (budget > 0)
            begin
                case ($urandom_range(0, 7))
                    0:       value = 8'h00;
                    1:       value = 8'hFF;
                    2:       value = 8'hC0;
                    3:       value = 8'h3F;
                    4:       value = prev_value;
                    default: value = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: run_len = $urandom_range(1, 3);
                    5, 6, 7:       run_len = $urandom_range(4, 20);
                    default:       run_len = $urandom_range(55, 70);
                endcase
                if (run_len > budget)
                    run_len = budget;
                while (run_len > 0)
                begin
                    // Now and then a stray pixel breaks the run.
                    if ($urandom_range(0, 29) == 0)
                        send_pixel(8'($urandom_range(0, 255)));
                    else
                        send_pixel(value);
                    run_len--;
                    budget--;
                    sent++;
                end
                prev_value = value;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        pixel          = 8'd0;
        cfg_valid      = 1'b0;
        line_width     = 16'd0;
        hold_request   = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        burst_left     = 0;
        enc_run_value  = 8'd0;
        enc_run_length = 6'd0;
        enc_column     = 16'd0;
        enc_width      = pcxrle_pkg::LINE_WIDTH_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_width();
        test_zero_width();
        test_line_end();
        test_width_lowered();
        test_output_stall();
        test_random_lines();

        wait_idle();
        if (error_count == 0)
            $display("[pcx_rle_line_encoder_unit] OK");
        else
            $display("[pcx_rle_line_encoder_unit] ERROR");
        $finish;
    end

endmodule
